FILE: hw/rtl/sae_pkg.sv
`timescale 1ns / 1ps

package sae_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned MAG_W = 11;
  localparam int unsigned SUM_W = 10;

  localparam logic [7:0] CFG_ROW_WIDTH = 8'd0;
  localparam logic [7:0] CFG_OUT_ROWS  = 8'd1;

  localparam logic [7:0] MIN_WIDTH     = 8'd3;
  localparam logic [7:0] MAX_OUT_ROWS  = 8'd253;
  localparam logic [7:0] BORDER        = 8'd2;
  localparam logic [7:0] RST_WIDTH     = 8'd16;
  localparam logic [7:0] RST_OUT_ROWS  = 8'd14;

  localparam logic [MAG_W-1:0] SAT_LIMIT  = 11'd255;
  localparam logic [7:0]       SPACE_CHAR = 8'd32;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] SHADE [16] = '{
    8'd64, 8'd37, 8'd38, 8'd36, 8'd35, 8'd111, 8'd115, 8'd197,
    8'd63, 8'd33, 8'd42, 8'd43, 8'd61, 8'd95, 8'd45, 8'd32
  };

  typedef struct packed {
    logic valid;
    logic prod;
    logic last;
  } req_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } occ_t;

  typedef struct packed {
    logic [7:0]       ascii_char;
    logic [MAG_W-1:0] magnitude;
    logic             last;
  } res_t;

  function automatic logic [SUM_W-1:0] absdiff(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [SUM_W-1:0] wsum(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

endpackage

FILE: hw/rtl/sae_ram.sv
`timescale 1ns / 1ps

module sae_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sae_grad.sv
`timescale 1ns / 1ps

module sae_grad import sae_pkg::*; #(
  parameter int unsigned AW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  req_t             req_i,
  input  logic [AW-1:0]    req_addr_i,
  input  logic [PIX_W-1:0] req_pix_i,
  input  logic [PIX_W-1:0] rd_upper_i,
  input  logic [PIX_W-1:0] rd_middle_i,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [PIX_W-1:0] wr_upper_o,
  output logic [PIX_W-1:0] wr_middle_o,
  output occ_t             occ_o,
  output logic             res_valid_o,
  output res_t             res_o
);

  req_t             s1_q;
  logic [AW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             fwd_q;
  logic             fwd_d;
  logic [PIX_W-1:0] fwd_top_q;
  logic [PIX_W-1:0] fwd_mid_q;
  logic [PIX_W-1:0] win_q [6];
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;

  logic             s2_valid_q;
  logic             s2_last_q;
  logic [SUM_W-1:0] left_q;
  logic [SUM_W-1:0] right_q;
  logic [SUM_W-1:0] upper_q;
  logic [SUM_W-1:0] lower_q;
  logic [MAG_W-1:0] mag;

  // previous beat writes the entry this beat reads: take its data instead
  assign fwd_d = req_i.valid && s1_q.valid && (s1_addr_q == req_addr_i);
  assign top   = fwd_q ? fwd_top_q : rd_upper_i;
  assign mid   = fwd_q ? fwd_mid_q : rd_middle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      fwd_q      <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      s1_q       <= req_i;
      fwd_q      <= fwd_d;
      s2_valid_q <= s1_q.valid && s1_q.prod;
      s2_last_q  <= s1_q.last;
      if (s1_q.valid) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= req_addr_i;
    s1_pix_q  <= req_pix_i;
    fwd_top_q <= mid;
    fwd_mid_q <= s1_pix_q;
    left_q    <= wsum(win_q[0], win_q[1], win_q[2]);
    right_q   <= wsum(top, mid, s1_pix_q);
    upper_q   <= wsum(win_q[0], win_q[3], top);
    lower_q   <= wsum(win_q[2], win_q[5], s1_pix_q);
  end

  assign wr_en_o     = s1_q.valid;
  assign wr_addr_o   = s1_addr_q;
  assign wr_upper_o  = mid;
  assign wr_middle_o = s1_pix_q;

  assign mag = {1'b0, absdiff(left_q, right_q)} + {1'b0, absdiff(upper_q, lower_q)};

  assign res_valid_o      = s2_valid_q;
  assign res_o.magnitude  = mag;
  assign res_o.ascii_char = (mag > SAT_LIMIT) ? SPACE_CHAR : SHADE[mag[7:4]];
  assign res_o.last       = s2_last_q;

  assign occ_o.s1 = s1_q.valid;
  assign occ_o.s2 = s2_valid_q;

endmodule

FILE: hw/rtl/sae_ofifo.sv
`timescale 1ns / 1ps

module sae_ofifo import sae_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  res_t               data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output res_t               data_o,
  output logic [FIFO_CW-1:0] count_o
);

  res_t               buf_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] rd_ptr_q;
  logic [FIFO_PW-1:0] wr_ptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               pop;

  assign pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: hw/rtl/sobel_ascii_edge_stream.sv
`timescale 1ns / 1ps
// Sobel 3x3 edge detector on a raster pixel stream, one shade character per
// interior pixel.
// Input: in_valid_i / in_stall_o, one gray pixel per beat; in_frame_start_i
// on the first pixel of a frame clears the row and column counters.
// Output: out_valid_o / out_stall_i, one beat per interior pixel carrying the
// character, |gx|+|gy| and a flag on the last result of the frame.
// Config: cfg_valid_i / cfg_ready_o, index 0 row_width, index 1 out_rows;
// always ready, write only between frames.
// Throughput: one pixel per clock while in_stall_o is low. A result passes the
// line store read, the window sums and the magnitude before it leaves.
// The two line stores are dual-port RAMs with a registered read; a write
// and a read of the same column in adjacent cycles are forwarded.
// A four-beat output queue absorbs receiver stalls; in_stall_o rises only
// when queue plus in-flight beats would overfill it.
// Reset clears counters, window and queue and loads width 16, 14 rows;
// line store contents are undefined until a row has passed.
module sobel_ascii_edge_stream import sae_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PIX_W-1:0] in_pixel_i,
  input  logic             in_frame_start_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_ascii_char_o,
  output logic [MAG_W-1:0] out_magnitude_o,
  output logic             out_last_of_frame_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i
);

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CAP   = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
  localparam logic [7:0]  CAP_W = 8'(CAP);
  localparam logic [7:0]  RST_W_LAST = ((RST_WIDTH < CAP_W) ? RST_WIDTH : CAP_W) - 8'd1;

  logic [7:0] w_last_q;
  logic [7:0] rows_last_q;
  logic [7:0] col_q;
  logic [7:0] row_q;

  logic       accept;
  logic [7:0] col_base;
  logic [7:0] row_base;
  logic [7:0] col;
  logic       active;
  logic       row_end;
  logic [7:0] w_clamp;
  logic [7:0] r_clamp;

  req_t             req;
  occ_t             occ;
  logic [AW-1:0]    addr;
  logic [PIX_W-1:0] rd_upper;
  logic [PIX_W-1:0] rd_middle;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_upper;
  logic [PIX_W-1:0] wr_middle;
  logic             res_valid;
  res_t             res;
  res_t             out_res;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [FIFO_CW:0]   pending;

  assign cfg_ready_o = 1'b1;

  assign w_clamp = (cfg_data_i < MIN_WIDTH) ? MIN_WIDTH :
                   (cfg_data_i > CAP_W) ? CAP_W : cfg_data_i;
  assign r_clamp = (cfg_data_i > MAX_OUT_ROWS) ? MAX_OUT_ROWS : cfg_data_i;

  assign accept   = in_valid_i && !in_stall_o;
  assign col_base = in_frame_start_i ? 8'd0 : col_q;
  assign row_base = in_frame_start_i ? 8'd0 : row_q;
  assign active   = row_base <= rows_last_q;
  assign col      = (col_base > w_last_q) ? w_last_q : col_base;
  assign row_end  = col == w_last_q;
  assign addr     = AW'(col);

  assign req.valid = accept && active;
  assign req.prod  = (row_base >= BORDER) && (col >= BORDER);
  assign req.last  = (row_base == rows_last_q) && row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q    <= RST_W_LAST;
      rows_last_q <= RST_OUT_ROWS + 8'd1;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ROW_WIDTH: w_last_q    <= w_clamp - 8'd1;
          CFG_OUT_ROWS:  rows_last_q <= r_clamp + 8'd1;
          default: ;
        endcase
      end
      if (accept) begin
        if (!active) begin
          col_q <= col_base;
          row_q <= row_base;
        end else if (row_end) begin
          col_q <= '0;
          row_q <= row_base + 8'd1;
        end else begin
          col_q <= col + 8'd1;
          row_q <= row_base;
        end
      end
    end
  end

  sae_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_upper),
    .re_i    (accept),
    .raddr_i (addr),
    .rdata_o (rd_upper)
  );

  sae_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_middle),
    .re_i    (accept),
    .raddr_i (addr),
    .rdata_o (rd_middle)
  );

  sae_grad #(.AW(AW)) u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_addr_i  (addr),
    .req_pix_i   (in_pixel_i),
    .rd_upper_i  (rd_upper),
    .rd_middle_i (rd_middle),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_upper_o  (wr_upper),
    .wr_middle_o (wr_middle),
    .occ_o       (occ),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sae_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_res),
    .count_o (fifo_cnt)
  );

  // beats already in the pipe must still find room in the queue
  assign pending    = {1'b0, fifo_cnt} + (FIFO_CW + 1)'(occ.s1) + (FIFO_CW + 1)'(occ.s2);
  assign in_stall_o = pending >= (FIFO_CW + 1)'(FIFO_DEPTH);

  assign out_ascii_char_o    = out_res.ascii_char;
  assign out_magnitude_o     = out_res.magnitude;
  assign out_last_of_frame_o = out_res.last;

endmodule

FILE: hw/rtl/sae_checker.sv
`timescale 1ns / 1ps

module sae_checker import sae_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [7:0]       out_ascii_char_o,
  input logic [MAG_W-1:0] out_magnitude_o,
  input logic             out_last_of_frame_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_ascii_char_o)
      && $stable(out_magnitude_o) && $stable(out_last_of_frame_o))
    else $error("output beat changed while stalled");

  a_saturated_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_magnitude_o > SAT_LIMIT) |-> out_ascii_char_o == SPACE_CHAR)
    else $error("saturated magnitude without space character");

  a_stall_has_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with nothing waiting at the output");

  a_first_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 3))
    else $error("output beat appeared without a pixel three cycles before");

endmodule

bind sobel_ascii_edge_stream sae_checker u_sae_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .out_ascii_char_o    (out_ascii_char_o),
  .out_magnitude_o     (out_magnitude_o),
  .out_last_of_frame_o (out_last_of_frame_o)
);

FILE: test/sobel_ascii_edge_stream_tb.sv
`timescale 1ns / 1ps

module sobel_ascii_edge_stream_tb;
  import sae_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PIXEL_TARGET = 1300;
  localparam logic [7:0]  CFG_UNUSED   = 8'hFF;

  localparam logic [7:0] CHAR_RAMP [16] = '{
    8'd64, 8'd37, 8'd38, 8'd36, 8'd35, 8'd111, 8'd115, 8'd197,
    8'd63, 8'd33, 8'd42, 8'd43, 8'd61, 8'd95, 8'd45, 8'd32
  };

  // diagonal edge giving the largest reachable magnitude
  localparam logic [7:0] DIAG_PIX [9] = '{
    8'd255, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0
  };
  // two windows either side of saturation (256, then 254)
  localparam logic [7:0] SAT_PIX [12] = '{
    8'd1, 8'd0, 8'd0, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_BINARY, PIX_RAMP} pix_mode_e;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  class sobel_tracker;
    logic [7:0]  upper [256];
    logic [7:0]  middle [256];
    logic [7:0]  win [6];
    int unsigned col, row;
    logic [7:0]  width_reg, rows_reg;
    res_t        pending [$];
    int unsigned used, ignored, checked, errors;

    function new();
      foreach (upper[i]) begin
        upper[i] = '0;
        middle[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0;
      row = 0;
      width_reg = 8'd16;
      rows_reg = 8'd14;
      used = 0;
      ignored = 0;
      checked = 0;
      errors = 0;
    endfunction

    function int unsigned line_len();
      return (width_reg < 8'd3) ? 3 : width_reg;
    endfunction

    function int unsigned frame_rows();
      return ((rows_reg > 8'd253) ? 253 : rows_reg) + 2;
    endfunction

    function bit frame_done();
      return row >= frame_rows();
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      case (idx)
        CFG_ROW_WIDTH: width_reg = val;
        CFG_OUT_ROWS:  rows_reg = val;
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int unsigned absgap(int unsigned a, int unsigned b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function void take_pixel(logic [7:0] pix, logic fs);
      int unsigned w, c, top, mid, lsum, rsum, usum, dsum, mag;
      res_t exp_r;
      w = line_len();
      if (fs) begin
        col = 0;
        row = 0;
      end
      if (row >= frame_rows()) begin
        ignored++;
        return;
      end
      used++;
      c = (col >= w) ? w - 1 : col;
      top = 32'(upper[c]);
      mid = 32'(middle[c]);
      if (row >= 2 && c >= 2) begin
        lsum = win[0] + 2 * win[1] + win[2];
        rsum = top + 2 * mid + pix;
        usum = win[0] + 2 * win[3] + top;
        dsum = win[2] + 2 * win[5] + pix;
        mag = absgap(lsum, rsum) + absgap(usum, dsum);
        exp_r.ascii_char = (mag > 255) ? SPACE_CHAR : CHAR_RAMP[mag >> 4];
        exp_r.magnitude = mag[MAG_W-1:0];
        exp_r.last = (row == frame_rows() - 1) && (c == w - 1);
        pending.push_back(exp_r);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top[7:0];
      win[4] = mid[7:0];
      win[5] = pix;
      upper[c] = mid[7:0];
      middle[c] = pix;
      if (c + 1 >= w) begin
        col = 0;
        row++;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_result(logic [7:0] ch, logic [MAG_W-1:0] mag, logic last);
      res_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result: char %0d mag %0d last %0b", ch, mag, last));
        return;
      end
      want = pending.pop_front();
      if (want.ascii_char !== ch || want.magnitude !== mag || want.last !== last)
        report($sformatf("result %0d: char %0d/%0d mag %0d/%0d last %0b/%0b (exp/got)",
                         checked, want.ascii_char, ch, want.magnitude, mag, want.last, last));
    endfunction

    function void flush_check();
      if (pending.size() != 0)
        report($sformatf("%0d results never arrived", pending.size()));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [PIX_W-1:0] in_pixel_i = '0;
  logic             in_frame_start_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_ascii_char_o;
  logic [MAG_W-1:0] out_magnitude_o;
  logic             out_last_of_frame_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [7:0]       cfg_index_i = CFG_ROW_WIDTH;
  logic [7:0]       cfg_data_i = '0;

  sobel_tracker tracker;
  int           burst_left = 0;
  bit           hold_request = 1'b0;
  int unsigned  cfg_writes = 0;
  int unsigned  frames = 0;

  sobel_ascii_edge_stream dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(out_ascii_char_o, out_magnitude_o, out_last_of_frame_o);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("sobel_ascii_edge_stream_tb: errors");
    $finish;
  end

  // receiver stall pattern, with one long hold on request
  initial begin : rx_side
    rx_mode_e mode;
    int       seg, per;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      seg = $urandom_range(20, 150);
      per = $urandom_range(2, 7);
      for (int k = 0; k < seg; k++) begin
        @(negedge clk_i);
        if (hold_request) begin
          hold_request = 1'b0;
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES - 1) begin
            @(negedge clk_i);
            out_stall_i <= 1'b1;
          end
        end else begin
          case (mode)
            RX_OPEN:  out_stall_i <= 1'b0;
            RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
            default:  out_stall_i <= ((k % per) < per / 2);
          endcase
        end
      end
    end
  end

  function automatic logic [7:0] make_pixel(pix_mode_e mode, int idx, int base, int step);
    int v;
    case (mode)
      PIX_NOISE: v = $urandom_range(0, 255);
      PIX_SMOOTH: begin
        v = base + $urandom_range(0, step);
        if (v > 255) v = 255;
      end
      PIX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
      default: v = (base + idx * step) % 256;
    endcase
    return v[7:0];
  endfunction

  // one pixel beat, sender bursts and gaps folded in
  task automatic put_pixel(input logic [7:0] pix, input logic fs);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      repeat ($urandom_range(0, 5)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_pixel_i <= pix;
    in_frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_pixel(pix, fs);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_config(input logic [7:0] width, input logic [7:0] rows);
    write_reg(CFG_ROW_WIDTH, width);
    write_reg(CFG_OUT_ROWS, rows);
  endtask

  // width only shrinks mid-frame, so no unwritten line store entry is read
  task automatic run_frame(input int trunc_at, input int change_at);
    pix_mode_e   mode;
    int          base, step, idx;
    int unsigned w_now;
    logic [7:0]  nw;
    mode = pix_mode_e'($urandom_range(0, 3));
    base = $urandom_range(0, 255);
    step = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(7, 64);
    idx = 0;
    frames++;
    put_pixel(make_pixel(mode, idx, base, step), 1'b1);
    idx++;
    while (!tracker.frame_done() && idx != trunc_at) begin
      if (idx == change_at) begin
        settle();
        w_now = tracker.line_len();
        nw = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) :
                                           8'($urandom_range(3, w_now));
        write_config(nw, 8'($urandom_range(0, 10)));
        if (tracker.frame_done()) break;
      end
      put_pixel(make_pixel(mode, idx, base, step), 1'b0);
      idx++;
    end
    if (tracker.frame_done() && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) put_pixel(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic pick_config();
    int         sel;
    logic [7:0] w, r;
    sel = $urandom_range(0, 19);
    if (sel == 0) w = 8'($urandom_range(0, 2));
    else if (sel == 1) w = 8'($urandom_range(25, 255));
    else w = 8'($urandom_range(3, 24));
    if (sel == 1) r = 8'($urandom_range(0, 2));
    else r = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
    write_config(w, r);
    if ($urandom_range(0, 19) == 0) write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int r;
    tracker = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry
    run_frame(0, 0);
    settle();

    write_config(8'd0, 8'd1);
    write_reg(CFG_UNUSED, 8'h5A);
    for (int i = 0; i < 9; i++) put_pixel(DIAG_PIX[i], i == 0);
    put_pixel(8'd255, 1'b0);
    put_pixel(8'd0, 1'b0);
    settle();
    write_config(8'd1, 8'd2);
    for (int i = 0; i < 12; i++) put_pixel(SAT_PIX[i], i == 0);
    settle();
    write_config(8'd2, 8'd0);
    for (int i = 0; i < 6; i++) put_pixel(8'($urandom_range(0, 255)), i == 0);
    put_pixel(8'hAA, 1'b0);
    settle();

    write_config(8'd100, 8'd1);
    run_frame(0, 0);
    settle();
    write_config(8'd3, 8'd60);
    hold_request = 1'b1;
    run_frame(0, 0);
    settle();

    while (tracker.used < PIXEL_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        pick_config();
      end
      r = $urandom_range(0, 7);
      run_frame((r == 0) ? $urandom_range(1, 40) : 0, (r == 1) ? $urandom_range(1, 40) : 0);
    end

    settle();
    tracker.flush_check();
    $display("tb summary: %0d frames, %0d pixels used, %0d ignored, %0d register writes",
             frames, tracker.used, tracker.ignored, cfg_writes);
    $display("tb summary: %0d results checked, %0d failures", tracker.checked, tracker.errors);
    if (tracker.errors == 0)
      $display("sobel_ascii_edge_stream_tb: clean");
    else
      $display("sobel_ascii_edge_stream_tb: errors");
    $finish;
  end

endmodule
